/* design/mrf_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// request framer.
// ---------------------------------------------------------------------------
package mrf_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned CRC_SPAN  = 6;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);

	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  SLAVE_RESET     = 8'h01;

	typedef enum logic {
		OP_WRITE_SINGLE = 1'b0,
		OP_READ_HOLDING = 1'b1
	} op_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [FRAME_LEN-1:0] frame_t;

	// one byte through the reflected CRC, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* design/mrf_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_if
// Valid/ready channels of the framer: request in, frame bytes out.
// ---------------------------------------------------------------------------
interface mrf_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] register_address;
	logic [15:0] register_value;

	modport source (output valid, output op, output register_address,
		output register_value, input ready);
	modport sink (input valid, input op, input register_address,
		input register_value, output ready);
endinterface

interface mrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink (input valid, input frame_byte, input last, output ready);
endinterface
`default_nettype wire

/* design/mrf_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_front
// Accepts a request, lays out the six header bytes and runs the CRC over
// them one byte per cycle, then pushes the complete frame to the queue.
// ---------------------------------------------------------------------------
module mrf_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          slave_address,
	mrf_req_if.sink             req,
	output logic                push_valid,
	input  wire                 push_ready,
	output mrf_pkg::frame_t     push_frame
);

	logic                       busy_q;
	logic [mrf_pkg::IDX_W-1:0]  cnt_q;
	logic [15:0]                crc_q;
	mrf_pkg::frame_t            hdr_q;
	logic                       crc_run;
	logic                       accept;

	always_comb begin
		crc_run    = busy_q && (cnt_q != mrf_pkg::IDX_W'(mrf_pkg::CRC_SPAN));
		push_valid = busy_q && (cnt_q == mrf_pkg::IDX_W'(mrf_pkg::CRC_SPAN));
		req.ready  = !busy_q || (push_valid && push_ready);
		accept     = req.valid && req.ready;
		push_frame    = hdr_q;
		push_frame[6] = crc_q[7:0];
		push_frame[7] = crc_q[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (crc_run) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (push_valid && push_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q[0] <= slave_address;
			hdr_q[1] <= (mrf_pkg::op_t'(req.op) == mrf_pkg::OP_READ_HOLDING) ?
				mrf_pkg::FC_READ_HOLDING : mrf_pkg::FC_WRITE_SINGLE;
			hdr_q[2] <= req.register_address[15:8];
			hdr_q[3] <= req.register_address[7:0];
			hdr_q[4] <= req.register_value[15:8];
			hdr_q[5] <= req.register_value[7:0];
			hdr_q[6] <= '0;
			hdr_q[7] <= '0;
			crc_q    <= mrf_pkg::CRC_INIT;
		end else if (crc_run) begin
			crc_q <= mrf_pkg::crc_byte(crc_q, hdr_q[cnt_q]);
		end
	end

endmodule
`default_nettype wire

/* design/mrf_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_queue
// Short frame queue between the CRC front and the byte serializer.
// ---------------------------------------------------------------------------
module mrf_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  mrf_pkg::frame_t  push_frame,
	output logic             pop_valid,
	input  wire              pop_ready,
	output mrf_pkg::frame_t  pop_frame
);

	mrf_pkg::frame_t             mem [mrf_pkg::QDEPTH];
	logic [mrf_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [mrf_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [mrf_pkg::QPTR_W:0]    count_q;
	logic                        do_push;
	logic                        do_pop;

	always_comb begin
		push_ready = (count_q != (mrf_pkg::QPTR_W+1)'(mrf_pkg::QDEPTH));
		pop_valid  = (count_q != '0);
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
		pop_frame  = mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mrf_pkg::QPTR_W'(mrf_pkg::QDEPTH-1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mrf_pkg::QPTR_W'(mrf_pkg::QDEPTH-1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_frame;
		end
	end

endmodule
`default_nettype wire

/* design/mrf_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_back
// Byte serializer: takes one frame from the queue and sends its eight
// bytes through a registered output, low index first.
// ---------------------------------------------------------------------------
module mrf_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              pop_valid,
	output logic             pop_ready,
	input  mrf_pkg::frame_t  pop_frame,
	mrf_byte_if.source       frm
);

	mrf_pkg::frame_t            frame_q;
	logic [mrf_pkg::IDX_W-1:0]  idx_q;
	logic                       active_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_last_q;
	logic                       adv;
	logic                       at_end;

	always_comb begin
		adv       = active_q && (!out_valid_q || frm.ready);
		at_end    = (idx_q == mrf_pkg::IDX_W'(mrf_pkg::FRAME_LEN-1));
		// next frame loads in the same cycle the last byte moves into the output register
		pop_ready = !active_q || (adv && at_end);
		frm.valid      = out_valid_q;
		frm.frame_byte = out_byte_q;
		frm.last       = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (frm.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else begin
				if (adv) begin
					idx_q <= idx_q + 1'b1;
				end
				if (adv && at_end) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			frame_q <= pop_frame;
		end
		if (adv) begin
			out_byte_q <= frame_q[idx_q];
			out_last_q <= at_end;
		end
	end

endmodule
`default_nettype wire

/* design/modbus_rtu_request_framer_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// modbus_rtu_request_framer_unit
// Builds Modbus RTU request frames (address, function, register, value,
// CRC-16/MODBUS) and streams them out one byte per transfer.
// ---------------------------------------------------------------------------
// Usage:
//  req  : one request per transfer (op, register_address, register_value).
//  frm  : eight byte transfers per request; last marks the CRC high byte.
//  cfg  : cfg_we/cfg_wdata write the station address (reset value 1);
//         write only while no frame is pending.
//  Path: a request passes the CRC front, the frame queue and the registered
//  byte output. The byte serializer sets the request rate; the CRC front
//  runs one byte per cycle through the byte-wide CRC update, can take a new
//  request as it pushes the finished frame, and runs ahead through a 2-entry
//  frame queue. Bytes of consecutive frames come out back to back.
//  Stalls: frame bytes hold while frm.ready is low; the queue then fills
//  and req.ready stays low while the CRC runs and while the frame cannot be pushed.
//  Reset clears all control state and returns the station address to 1;
//  no frame is in flight after reset.
// ---------------------------------------------------------------------------
module modbus_rtu_request_framer_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [7:0] cfg_wdata,
	mrf_req_if.sink    req,
	mrf_byte_if.source frm
);

	logic [7:0]       slave_q;
	logic             push_valid;
	logic             push_ready;
	mrf_pkg::frame_t  push_frame;
	logic             pop_valid;
	logic             pop_ready;
	mrf_pkg::frame_t  pop_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= mrf_pkg::SLAVE_RESET;
		end else if (cfg_we) begin
			slave_q <= cfg_wdata;
		end
	end

	mrf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_q),
		.req           (req),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_frame    (push_frame)
	);

	mrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_frame  (pop_frame)
	);

	mrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_frame (pop_frame),
		.frm       (frm)
	);

endmodule
`default_nettype wire

/* design/mrf_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mrf_checker
// Port-level checks of the framer: byte framing, function codes, no
// bytes without a pending request, stalled output holds.
// ---------------------------------------------------------------------------
module mrf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        frm_valid,
	input wire        frm_ready,
	input wire  [7:0] frm_byte,
	input wire        frm_last
);

	logic [mrf_pkg::IDX_W-1:0] pos_q;
	logic [2:0]                pend_q;
	logic                      req_xfer;
	logic                      frm_xfer;
	logic                      frm_end;

	always_comb begin
		req_xfer = req_valid && req_ready;
		frm_xfer = frm_valid && frm_ready;
		frm_end  = frm_xfer && frm_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
		end else begin
			if (frm_xfer) begin
				pos_q <= pos_q + 1'b1;
			end
			if (req_xfer && !frm_end) begin
				pend_q <= pend_q + 1'b1;
			end else if (frm_end && !req_xfer) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		frm_xfer |-> (frm_last == (pos_q == mrf_pkg::IDX_W'(mrf_pkg::FRAME_LEN-1))))
		else $error("last flag not on eighth byte");

	a_func_code: assert property (@(posedge clk) disable iff (!arst_n)
		(frm_xfer && pos_q == mrf_pkg::IDX_W'(1)) |->
		(frm_byte == mrf_pkg::FC_WRITE_SINGLE || frm_byte == mrf_pkg::FC_READ_HOLDING))
		else $error("bad function code byte");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid |-> (pend_q != '0))
		else $error("frame byte without pending request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(frm_valid && !frm_ready) |=>
		(frm_valid && $stable(frm_byte) && $stable(frm_last)))
		else $error("stalled frame byte changed");

endmodule

bind modbus_rtu_request_framer_unit mrf_checker u_mrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.frm_valid (frm.valid),
	.frm_ready (frm.ready),
	.frm_byte  (frm.frame_byte),
	.frm_last  (frm.last)
);
`default_nettype wire

/* test/mrf_frame_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mrf_frame_checker
// Watches the request and frame byte channels. For every request transfer it
// builds the expected 8-byte frame from its own copy of the station address:
// address, function code, register, value, and a CRC-16/MODBUS computed here.
// It then checks each byte transfer against the oldest expected byte.
// ---------------------------------------------------------------------------
module mrf_frame_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [7:0] cfg_wdata,
	mrf_req_if         req,
	mrf_byte_if        frm,
	output int         mismatches,
	output int         pending
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		mrf_pkg::byte_t frame_byte;
		logic           last;
	} frame_beat_t;

	frame_beat_t    expected_beats[$];
	mrf_pkg::byte_t station_addr;

	function automatic mrf_pkg::frame_t predict_request_frame(input mrf_pkg::byte_t station,
		input mrf_pkg::op_t op, input logic [15:0] reg_addr, input logic [15:0] reg_value);
		mrf_pkg::frame_t f;
		logic [15:0]     crc;
		int              n;
		int              b;
		f[0] = station;
		f[1] = (op == mrf_pkg::OP_READ_HOLDING) ? mrf_pkg::FC_READ_HOLDING :
			mrf_pkg::FC_WRITE_SINGLE;
		f[2] = reg_addr[15:8];
		f[3] = reg_addr[7:0];
		f[4] = reg_value[15:8];
		f[5] = reg_value[7:0];
		// reflected CRC, LSB of each byte first
		crc = mrf_pkg::CRC_INIT;
		for (n = 0; n < mrf_pkg::CRC_SPAN; n++) begin
			crc = crc ^ {8'h00, f[n]};
			for (b = 0; b < 8; b++) begin
				if (crc[0])
					crc = (crc >> 1) ^ mrf_pkg::CRC_POLY;
				else
					crc = crc >> 1;
			end
		end
		f[6] = crc[7:0];
		f[7] = crc[15:8];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		mrf_pkg::frame_t f;
		frame_beat_t     want;
		frame_beat_t     got;
		int              n;
		if (!arst_n) begin
			station_addr <= mrf_pkg::SLAVE_RESET;
			expected_beats.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				station_addr <= cfg_wdata;

			if (frm.valid && frm.ready) begin
				got.frame_byte = frm.frame_byte;
				got.last = frm.last;
				if (expected_beats.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected frame byte transfer: byte %02h last %0b",
							$realtime, got.frame_byte, got.last);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						if (mismatches < REPORT_LIMIT)
							$display({"%0t: frame byte mismatch: expected byte %02h last %0b,",
								" got byte %02h last %0b"}, $realtime, want.frame_byte,
								want.last, got.frame_byte, got.last);
						mismatches <= mismatches + 1;
					end
				end
			end

			if (req.valid && req.ready) begin
				f = predict_request_frame(station_addr, mrf_pkg::op_t'(req.op),
					req.register_address, req.register_value);
				for (n = 0; n < mrf_pkg::FRAME_LEN; n++) begin
					want.frame_byte = f[n];
					want.last = (n == mrf_pkg::FRAME_LEN - 1);
					expected_beats.insert(expected_beats.size(), want);
				end
			end

			pending <= expected_beats.size();
		end
	end

endmodule

/* test/tb_modbus_rtu_request_framer_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_modbus_rtu_request_framer_unit
// Drives Modbus RTU requests into the framer under several station addresses
// and random handshake gaps on both sides. It adds a long output stall and
// a full drain partway through. The frame checker predicts and compares
// every byte.
// ---------------------------------------------------------------------------
module tb_modbus_rtu_request_framer_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 120;
	localparam int SETTLE_CYCLES  = 20;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	int sender_idle_pct;
	int receiver_idle_pct;
	int holds_asked = 0;
	int holds_done = 0;
	int mismatch_count;
	int pending_bytes;

	mrf_req_if  req_ch();
	mrf_byte_if frm_ch();

	modbus_rtu_request_framer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.frm       (frm_ch)
	);

	mrf_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.frm        (frm_ch),
		.mismatches (mismatch_count),
		.pending    (pending_bytes)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly uniform, with the all-zero and all-one words showing up often
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_request(input mrf_pkg::op_t op, input logic [15:0] reg_addr,
		input logic [15:0] reg_value);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.register_address <= reg_addr;
		req_ch.register_value <= reg_value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// pending_bytes is registered by the checker, so this task steps the clock before looking at it
	task automatic drain_frames();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes != 0)
			@(posedge clk);
	endtask

	task automatic write_station(input mrf_pkg::byte_t value);
		drain_frames();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_request(mrf_pkg::op_t'($urandom_range(0, 1)), pick_word(), pick_word());
	endtask

	// output side: random backpressure plus requested long hold-offs
	initial begin
		frm_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				frm_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			frm_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// stall watchdog: any cycle without a transfer on either channel counts
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (frm_ch.valid && frm_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		req_ch.valid = 1'b0;
		req_ch.op = mrf_pkg::OP_WRITE_SINGLE;
		req_ch.register_address = 16'h0000;
		req_ch.register_value = 16'h0000;
		sender_idle_pct = 35;
		receiver_idle_pct = 51;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, station address still at its reset value
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h0000, 16'h0000);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'hFFFF, 16'hFFFF);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h0000, 16'h0000);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'hFFFF, 16'hFFFF);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h5555, 16'hAAAA);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'hAAAA, 16'h5555);
		// motor on / motor off / get speed style frames
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h0000, 16'h0001);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h0001, 16'h0000);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h0001, 16'h0001);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h8000, 16'h0001);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h0001, 16'h8000);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h00FF, 16'hFF00);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'hFF00, 16'h00FF);
		// read counts at and beyond the protocol limit go out unchanged
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h1234, 16'h007D);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h1234, 16'h007E);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h4321, 16'hFFFE);

		write_station(8'hFF);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'hFFFF, 16'hFFFF);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'h0000, 16'h0000);
		run_random(65);

		sender_idle_pct = 51;
		receiver_idle_pct = 35;
		write_station(8'h00);
		send_request(mrf_pkg::OP_READ_HOLDING, 16'hFFFF, 16'h0000);
		send_request(mrf_pkg::OP_WRITE_SINGLE, 16'h0000, 16'hFFFF);
		run_random(65);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_station(mrf_pkg::byte_t'($urandom_range(2, 254)));
		// long output stall while requests keep coming, fills the frame queue
		holds_asked++;
		run_random(35);
		drain_frames();
		run_random(35);

		drain_frames();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_bytes == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
